@@ design/load_segment_checker_macros.svh @@
// Assertion macros shared by the load segment checker modules.
// No dependencies; included by files that carry concurrent checks.
`ifndef LOAD_SEGMENT_CHECKER_MACROS_SVH
`define LOAD_SEGMENT_CHECKER_MACROS_SVH

// same-cycle implication, disabled in reset
`define LSC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("load segment checker: implication check failed");

// next-cycle implication, disabled in reset
`define LSC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("load segment checker: next-cycle check failed");

`endif

@@ design/lsc_pkg.sv @@
// Shared types and constants of the load segment checker.
// No dependencies; used by lsc_ctrl, lsc_dpath and load_segment_checker.
package lsc_pkg;

    localparam int STATUS_W = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W = 96;
    localparam int OUT_DATA_W = 104;
    localparam int COUNT_OUT_W = 5;

    localparam logic [STATUS_W-1:0] ST_RECORDED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_LOAD = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BEYOND   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 3'd4;
    localparam logic [STATUS_W-1:0] ST_OVERLAP  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd6;
    localparam logic [STATUS_W-1:0] ST_CLEAR    = 3'd0;

    localparam logic [CFG_ADDR_W-1:0] CFG_R0_BASE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_R0_SIZE   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_R1_BASE   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_R1_SIZE   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_R2_BASE   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_R2_SIZE   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_REGION_EN = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHECK_EN  = 3'd7;

    localparam logic [31:0] SEG_TYPE_LOAD = 32'd1;
    localparam logic [31:0] ADDR_ALL_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic load;
        logic eval;
        logic scan;
        logic decide;
        logic emit;
    } lsc_cmd_t;

    typedef struct packed {
        logic cand;
        logic scan_done;
        logic out_free;
    } lsc_sts_t;

endpackage

@@ design/lsc_ctrl.sv @@
// Sequencer of the load segment checker: accept, evaluate, scan, decide, emit.
// Depends on lsc_pkg and load_segment_checker_macros.svh.
`include "load_segment_checker_macros.svh"

module lsc_ctrl
    import lsc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  lsc_sts_t sts,
    output lsc_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EVAL   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (!sts.cand || sts.scan_done) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready   = (state_reg == S_IDLE);
    assign cmd.load   = s_tvalid && (state_reg == S_IDLE);
    assign cmd.eval   = (state_reg == S_EVAL);
    assign cmd.scan   = (state_reg == S_SCAN);
    assign cmd.decide = (state_reg == S_DECIDE);
    assign cmd.emit   = (state_reg == S_EMIT) && sts.out_free;

    `LSC_ASSERT_NXT(a_load_to_eval, aclk, aresetn, cmd.load, state_reg == S_EVAL)
    `LSC_ASSERT_NXT(a_skip_scan, aclk, aresetn, cmd.scan && !sts.cand, state_reg == S_DECIDE)
    `LSC_ASSERT_IMP(a_emit_free, aclk, aresetn, cmd.emit, sts.out_free)

endmodule

@@ design/lsc_dpath.sv @@
// Datapath of the load segment checker: config, image state, segment table, result.
// Depends on lsc_pkg and load_segment_checker_macros.svh.
`include "load_segment_checker_macros.svh"

module lsc_dpath
    import lsc_pkg::*;
#(
    parameter int MAX_SEGMENTS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    input  lsc_cmd_t              cmd,
    output lsc_sts_t              sts,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [STATUS_W-1:0]   m_tuser
);

    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int ADDR_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGMENTS);

    logic [31:0] base_reg [3];
    logic [31:0] rsize_reg [3];
    logic [2:0]  en_reg;
    logic        chk_reg;

    logic        last_reg;
    logic [31:0] type_reg;
    logic [31:0] start_reg;
    logic [31:0] size_reg;

    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    hidx_reg;
    logic [31:0]         low_reg;
    logic [31:0]         high_reg;
    logic [31:0]         sum_reg;
    logic [STATUS_W-1:0] sticky_reg;

    logic [STATUS_W-1:0] pre_reg;
    logic [STATUS_W-1:0] pre_next;
    logic                cand_reg;
    logic                cand_next;
    logic                skip_reg;
    logic                skip_next;
    logic [31:0]         end_reg;
    logic [STATUS_W-1:0] status_reg;

    logic [31:0] mem_start [MAX_SEGMENTS];
    logic [31:0] mem_end [MAX_SEGMENTS];

    logic [CNT_W-1:0] scan_idx_reg;
    logic [31:0]      rd_start_reg;
    logic [31:0]      rd_end_reg;
    logic             rd_valid_reg;
    logic             hit_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [CNT_W-1:0]    out_cnt_reg;
    logic [31:0]         out_low_reg;
    logic [31:0]         out_high_reg;
    logic [31:0]         out_sum_reg;

    logic [32:0]         end_sum;
    logic [2:0]          region_hit;
    logic                in_region;
    logic [STATUS_W-1:0] dec_status;
    logic                rec_en;
    logic                sticky_wr;
    logic [CNT_W+COUNT_OUT_W-1:0] cnt_wide;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++) begin
                base_reg[r]  <= '0;
                rsize_reg[r] <= '0;
            end
            en_reg  <= '0;
            chk_reg <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_R0_BASE:   base_reg[0]  <= cfg_wdata;
                CFG_R0_SIZE:   rsize_reg[0] <= cfg_wdata;
                CFG_R1_BASE:   base_reg[1]  <= cfg_wdata;
                CFG_R1_SIZE:   rsize_reg[1] <= cfg_wdata;
                CFG_R2_BASE:   base_reg[2]  <= cfg_wdata;
                CFG_R2_SIZE:   rsize_reg[2] <= cfg_wdata;
                CFG_REGION_EN: en_reg       <= cfg_wdata[2:0];
                CFG_CHECK_EN:  chk_reg      <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            last_reg  <= s_tlast;
            type_reg  <= s_tdata[31:0];
            start_reg <= s_tdata[63:32];
            size_reg  <= s_tdata[95:64];
        end
    end

    // header checks ahead of the table scan
    assign end_sum = {1'b0, start_reg} + {1'b0, size_reg};

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            region_hit[r] = en_reg[r] && (start_reg >= base_reg[r])
                && (end_sum[31:0] <= (base_reg[r] + rsize_reg[r]));
        end
    end

    assign in_region = !end_sum[32] && (region_hit != 3'b000);

    always_comb begin
        pre_next  = ST_RECORDED;
        cand_next = 1'b0;
        skip_next = 1'b0;
        if (sticky_reg != ST_CLEAR) begin
            pre_next  = sticky_reg;
            skip_next = 1'b1;
        end else if (hidx_reg >= MAX_CNT) begin
            pre_next = ST_BEYOND;
        end else if (type_reg != SEG_TYPE_LOAD) begin
            pre_next = ST_NOT_LOAD;
        end else if (size_reg == '0) begin
            pre_next = ST_EMPTY;
        end else if (chk_reg && !in_region) begin
            pre_next = ST_BAD_ADDR;
        end else begin
            cand_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            pre_reg  <= pre_next;
            cand_reg <= cand_next;
            skip_reg <= skip_next;
            end_reg  <= end_sum[31:0];
        end
    end

    always_comb begin
        dec_status = pre_reg;
        rec_en     = 1'b0;
        sticky_wr  = 1'b0;
        if (!skip_reg) begin
            if (cand_reg) begin
                if (hit_reg) begin
                    dec_status = ST_OVERLAP;
                end else begin
                    rec_en = 1'b1;
                end
            end
            if (dec_status == ST_BAD_ADDR || dec_status == ST_OVERLAP) begin
                sticky_wr = 1'b1;
            end else if (last_reg && cnt_reg == '0 && !rec_en) begin
                dec_status = ST_NONE;
                sticky_wr  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            hidx_reg   <= '0;
            low_reg    <= ADDR_ALL_ONES;
            high_reg   <= '0;
            sum_reg    <= '0;
            sticky_reg <= ST_CLEAR;
        end else if (cmd.load && s_tuser) begin
            cnt_reg    <= '0;
            hidx_reg   <= '0;
            low_reg    <= ADDR_ALL_ONES;
            high_reg   <= '0;
            sum_reg    <= '0;
            sticky_reg <= ST_CLEAR;
        end else if (cmd.eval) begin
            if (sticky_reg == ST_CLEAR && hidx_reg < MAX_CNT) begin
                hidx_reg <= hidx_reg + 1'b1;
            end
        end else if (cmd.decide) begin
            if (sticky_wr) begin
                sticky_reg <= dec_status;
            end
            if (rec_en) begin
                if (cnt_reg < MAX_CNT) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (start_reg < low_reg) begin
                    low_reg <= start_reg;
                end
                if (end_reg > high_reg) begin
                    high_reg <= end_reg;
                end
                sum_reg <= sum_reg + size_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide && rec_en && cnt_reg < MAX_CNT) begin
            mem_start[cnt_reg[ADDR_W-1:0]] <= start_reg;
            mem_end[cnt_reg[ADDR_W-1:0]]   <= end_reg;
        end
        if (cmd.scan && scan_idx_reg < cnt_reg) begin
            rd_start_reg <= mem_start[scan_idx_reg[ADDR_W-1:0]];
            rd_end_reg   <= mem_end[scan_idx_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end else if (cmd.eval) begin
            scan_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end else if (cmd.scan) begin
            if (scan_idx_reg < cnt_reg) begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                rd_valid_reg <= 1'b1;
            end else begin
                rd_valid_reg <= 1'b0;
            end
            if (rd_valid_reg && start_reg < rd_end_reg && rd_start_reg < end_reg) begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // hold the decided status until the output register is free
    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            status_reg <= dec_status;
        end
        if (cmd.emit) begin
            out_status_reg <= status_reg;
            out_cnt_reg    <= cnt_reg;
            out_low_reg    <= low_reg;
            out_high_reg   <= high_reg;
            out_sum_reg    <= sum_reg;
        end
    end

    assign cnt_wide      = {{COUNT_OUT_W{1'b0}}, out_cnt_reg};
    assign m_tvalid      = out_valid_reg;
    assign m_tuser       = out_status_reg;
    assign m_tdata       = {3'b000, out_sum_reg, out_high_reg, out_low_reg,
                            cnt_wide[COUNT_OUT_W-1:0]};
    assign sts.cand      = cand_reg;
    assign sts.scan_done = (scan_idx_reg == cnt_reg) && !rd_valid_reg;
    assign sts.out_free  = !out_valid_reg || m_tready;

    `LSC_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= MAX_CNT)
    `LSC_ASSERT_IMP(a_scan_bound, aclk, aresetn, cmd.scan, scan_idx_reg <= cnt_reg)
    `LSC_ASSERT_IMP(a_sticky_code, aclk, aresetn, 1'b1,
        sticky_reg == ST_CLEAR || sticky_reg == ST_BAD_ADDR
        || sticky_reg == ST_OVERLAP || sticky_reg == ST_NONE)
    `LSC_ASSERT_NXT(a_record_count, aclk, aresetn, cmd.decide && rec_en,
        cnt_reg == $past(cnt_reg) + 1'b1 || $past(cnt_reg) == MAX_CNT)

endmodule

@@ design/load_segment_checker.sv @@
// A header taken in IDLE passes through the EVAL, SCAN, DECIDE and EMIT states to the output
// register; SCAN reads one table entry a cycle for a candidate segment with entries recorded.
// EMIT waits while the output register is held; a new header is taken only after the emit.
// Reset: synchronous active-low aresetn clears the image state, sticky error and config
// (check_addresses to 1); the segment table needs no clearing.
// Depends on lsc_pkg, lsc_ctrl and lsc_dpath.
module load_segment_checker
    import lsc_pkg::*;
#(
    parameter int MAX_SEGMENTS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // seg_type, seg_start, seg_mem_size
    input  logic                  s_tuser,   // first_header
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // segment count, lowest_start, highest_end,
                                             // size sum, zero pad
    output logic [STATUS_W-1:0]   m_tuser    // status
);

    lsc_cmd_t cmd;
    lsc_sts_t sts;

    lsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lsc_dpath #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
